// ----- hdl/jsu_pkg.sv -----
// Shared types, character codes and helpers for the JSON string unescaper.
package jsu_pkg;

   // Decode mode of the escape parser
   typedef enum logic [3:0] {
      MODE_TEXT = 4'b0001,
      MODE_ESC  = 4'b0010,
      MODE_HEX  = 4'b0100,
      MODE_PAIR = 4'b1000
   } mode_type;

   // Sequencer states
   typedef enum logic [4:0] {
      ST_ACCEPT = 5'b00001,
      ST_REPLAY = 5'b00010,
      ST_EMIT   = 5'b00100,
      ST_FINISH = 5'b01000,
      ST_CLOSE  = 5'b10000
   } ctrl_state_type;

   // Commands from the sequencer to the datapath
   typedef struct packed {
      logic feed_input;
      logic feed_replay;
      logic emit_next;
      logic finish_step;
      logic close;
   } cmd_type;

   // Status from the datapath to the sequencer
   typedef struct packed {
      logic slot_free;
      logic more_replay;
      logic more_emit;
      logic mode_text;
   } status_type;

   localparam logic [7:0] CHAR_BSLASH = 8'h5C;
   localparam logic [7:0] CHAR_QMARK  = 8'h3F;
   localparam logic [7:0] CHAR_LC_U   = 8'h75;
   localparam logic [7:0] CHAR_LC_N   = 8'h6E;
   localparam logic [7:0] CHAR_LC_T   = 8'h74;
   localparam logic [7:0] CHAR_LC_R   = 8'h72;
   localparam logic [7:0] CHAR_LC_B   = 8'h62;
   localparam logic [7:0] CHAR_LC_F   = 8'h66;
   localparam logic [7:0] CODE_LF     = 8'h0A;
   localparam logic [7:0] CODE_TAB    = 8'h09;
   localparam logic [7:0] CODE_CR     = 8'h0D;
   localparam logic [7:0] CODE_BS     = 8'h08;
   localparam logic [7:0] CODE_FF     = 8'h0C;

   localparam logic [15:0] SUR_HI_FIRST = 16'hD800;
   localparam logic [15:0] SUR_HI_LAST  = 16'hDBFF;
   localparam logic [15:0] SUR_LO_FIRST = 16'hDC00;
   localparam logic [15:0] SUR_LO_LAST  = 16'hDFFF;
   localparam logic [20:0] PLANE1_BASE  = 21'h10000;

   localparam logic [7:0] UTF_LEAD2 = 8'hC0;
   localparam logic [7:0] UTF_LEAD3 = 8'hE0;
   localparam logic [7:0] UTF_LEAD4 = 8'hF0;
   localparam logic [7:0] UTF_CONT  = 8'h80;

   localparam logic [16:0] CAP_RESET = 17'd4096;

   // Hex digit value; bit 4 set marks a byte that is not a hex digit
   function automatic logic [4:0] hex_digit(input logic [7:0] b);
      logic [4:0] r;
      r = 5'h10;
      if (b >= 8'h30 && b <= 8'h39) r = 5'(b - 8'h30);
      else if (b >= 8'h61 && b <= 8'h66) r = 5'(b - 8'h57);
      else if (b >= 8'h41 && b <= 8'h46) r = 5'(b - 8'h37);
      return r;
   endfunction

endpackage

// ----- hdl/jsu_ctrl.sv -----
// Sequencer: picks the byte source and steps through emit, replay and close.
module jsu_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   input  logic                    req_tlast,
   output logic                    req_tready,
   input  jsu_pkg::status_type     status,
   output jsu_pkg::cmd_type        cmd
);

   jsu_pkg::ctrl_state_type state_ff, state_in;
   logic last_pend_ff, last_pend_in;
   logic advance;
   logic last_now;

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      last_pend_in = last_pend_ff;
      cmd          = '0;
      req_tready   = 1'b0;
      advance      = 1'b0;
      last_now     = last_pend_ff;
      unique case (state_ff)
         jsu_pkg::ST_ACCEPT: begin
            req_tready = status.slot_free;
            last_now   = req_tlast;
            if (req_tvalid && status.slot_free) begin
               cmd.feed_input = 1'b1;
               last_pend_in   = req_tlast;
               advance        = 1'b1;
            end
         end
         jsu_pkg::ST_REPLAY: begin
            if (status.slot_free) begin
               cmd.feed_replay = 1'b1;
               advance         = 1'b1;
            end
         end
         jsu_pkg::ST_EMIT: begin
            if (status.slot_free) begin
               cmd.emit_next = 1'b1;
               advance       = 1'b1;
            end
         end
         jsu_pkg::ST_FINISH: begin
            if (status.slot_free) begin
               cmd.finish_step = 1'b1;
               advance         = 1'b1;
            end
         end
         jsu_pkg::ST_CLOSE: begin
            if (status.slot_free) begin
               cmd.close    = 1'b1;
               last_pend_in = 1'b0;
               state_in     = jsu_pkg::ST_ACCEPT;
            end
         end
         default: begin
            state_in = jsu_pkg::ST_ACCEPT;
         end
      endcase
      // Dispatch after a step
      if (advance) begin
         priority if (status.more_emit) state_in = jsu_pkg::ST_EMIT;
         else if (status.more_replay)   state_in = jsu_pkg::ST_REPLAY;
         else if (last_now)
            state_in = status.mode_text ? jsu_pkg::ST_CLOSE : jsu_pkg::ST_FINISH;
         else                           state_in = jsu_pkg::ST_ACCEPT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= jsu_pkg::ST_ACCEPT;
         last_pend_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         last_pend_ff <= last_pend_in;
      end
   end

endmodule

// ----- hdl/jsu_datapath.sv -----
// Datapath: escape decoder, lookahead buffer, UTF-8 encoder and output register.
module jsu_datapath #(
   parameter int LENGTH_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  jsu_pkg::cmd_type        cmd,
   output jsu_pkg::status_type     status,
   input  logic [7:0]              req_byte,
   input  logic                    csr_valid,
   input  logic [16:0]             csr_data,
   input  logic                    rsp_tready,
   output logic                    rsp_valid,
   output logic                    rsp_kind,
   output logic [7:0]              rsp_byte,
   output logic [15:0]             rsp_length,
   output logic                    rsp_overflow,
   output logic                    rsp_last
);

   localparam int LIM_W = (LENGTH_BITS > 17) ? LENGTH_BITS : 17;

   logic [16:0]            cap_ff;
   jsu_pkg::mode_type      mode_ff, mode_in;
   logic [7:0]             buf_ff [6];
   logic [7:0]             buf_in [6];
   logic [2:0]             cnt_ff, cnt_in;
   logic [9:0]             hs_ff, hs_in;
   logic [20:0]            code_ff, code_in;
   logic [1:0]             rem_ff, rem_in;
   logic [2:0]             rp_idx_ff, rp_idx_in;
   logic [2:0]             rp_len_ff, rp_len_in;
   logic [LENGTH_BITS-1:0] written_ff, written_in;
   logic                   stopped_ff, stopped_in;
   logic                   ovf_ff, ovf_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_kind_ff, rsp_kind_in;
   logic [7:0]             rsp_byte_ff, rsp_byte_in;
   logic [15:0]            rsp_length_ff, rsp_length_in;
   logic                   rsp_ovf_ff, rsp_ovf_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic                   cap_zero;
   logic [LIM_W-1:0]       cap_m1, max_len, lim_wide;
   logic [LENGTH_BITS-1:0] limit;
   logic                   slot_free;

   // Byte limit: capacity minus one, saturated to the length range
   always_comb begin
      cap_zero = (cap_ff == '0);
      cap_m1   = LIM_W'(cap_ff) - LIM_W'(1);
      max_len  = LIM_W'({LENGTH_BITS{1'b1}});
      lim_wide = cap_zero ? '0 : ((cap_m1 > max_len) ? max_len : cap_m1);
      limit    = LENGTH_BITS'(lim_wide);
   end

   assign slot_free = !rsp_valid_ff || rsp_tready;

   // Decode step
   always_comb begin
      logic [7:0]  b;
      logic [4:0]  h0, h1, h2, hb;
      logic [4:0]  p2, p3, p4;
      logic [15:0] hexv, lov;
      logic        pair_fail;
      logic        emit_en;
      logic [7:0]  emit_val;
      logic        code_go;
      logic [20:0] code_val;
      logic        replay_go;
      logic [2:0]  replay_len;
      logic        room2, room3, room4;
      logic [5:0]  six;

      b          = cmd.feed_replay ? buf_ff[rp_idx_ff] : req_byte;
      h0         = jsu_pkg::hex_digit(buf_ff[0]);
      h1         = jsu_pkg::hex_digit(buf_ff[1]);
      h2         = jsu_pkg::hex_digit(buf_ff[2]);
      hb         = jsu_pkg::hex_digit(b);
      p2         = jsu_pkg::hex_digit(buf_ff[2]);
      p3         = jsu_pkg::hex_digit(buf_ff[3]);
      p4         = jsu_pkg::hex_digit(buf_ff[4]);
      hexv       = {h0[3:0], h1[3:0], h2[3:0], hb[3:0]};
      lov        = {p2[3:0], p3[3:0], p4[3:0], hb[3:0]};
      pair_fail  = (cnt_ff == 3'd0 && b != jsu_pkg::CHAR_BSLASH) ||
                   (cnt_ff == 3'd1 && b != jsu_pkg::CHAR_LC_U) ||
                   (cnt_ff >= 3'd2 && hb[4]);
      room2      = ({1'b0, written_ff} + (LENGTH_BITS+1)'(2)) <= {1'b0, limit};
      room3      = ({1'b0, written_ff} + (LENGTH_BITS+1)'(3)) <= {1'b0, limit};
      room4      = ({1'b0, written_ff} + (LENGTH_BITS+1)'(4)) <= {1'b0, limit};

      mode_in    = mode_ff;
      buf_in     = buf_ff;
      cnt_in     = cnt_ff;
      hs_in      = hs_ff;
      code_in    = code_ff;
      rem_in     = rem_ff;
      rp_idx_in  = rp_idx_ff;
      rp_len_in  = rp_len_ff;
      written_in = written_ff;
      stopped_in = stopped_ff;
      ovf_in     = ovf_ff;
      emit_en    = 1'b0;
      emit_val   = '0;
      code_go    = 1'b0;
      code_val   = '0;
      replay_go  = 1'b0;
      replay_len = '0;
      six        = code_ff[5:0];

      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_byte_in   = rsp_byte_ff;
      rsp_length_in = rsp_length_ff;
      rsp_ovf_in    = rsp_ovf_ff;
      rsp_last_in   = rsp_last_ff;

      if (cmd.feed_replay) rp_idx_in = rp_idx_ff + 3'd1;

      // Feed one byte
      if (cmd.feed_input || cmd.feed_replay) begin
         unique case (mode_ff)
            jsu_pkg::MODE_TEXT: begin
               if (!cap_zero && !stopped_ff) begin
                  if (written_ff >= limit) begin
                     stopped_in = 1'b1;
                     ovf_in     = 1'b1;
                  end else if (b == jsu_pkg::CHAR_BSLASH) begin
                     mode_in = jsu_pkg::MODE_ESC;
                  end else begin
                     emit_en  = 1'b1;
                     emit_val = b;
                  end
               end
            end
            jsu_pkg::MODE_ESC: begin
               mode_in = jsu_pkg::MODE_TEXT;
               emit_en = 1'b1;
               unique case (b)
                  jsu_pkg::CHAR_LC_N: emit_val = jsu_pkg::CODE_LF;
                  jsu_pkg::CHAR_LC_T: emit_val = jsu_pkg::CODE_TAB;
                  jsu_pkg::CHAR_LC_R: emit_val = jsu_pkg::CODE_CR;
                  jsu_pkg::CHAR_LC_B: emit_val = jsu_pkg::CODE_BS;
                  jsu_pkg::CHAR_LC_F: emit_val = jsu_pkg::CODE_FF;
                  jsu_pkg::CHAR_LC_U: begin
                     emit_en = 1'b0;
                     mode_in = jsu_pkg::MODE_HEX;
                     cnt_in  = '0;
                  end
                  default: emit_val = b;
               endcase
            end
            jsu_pkg::MODE_HEX: begin
               buf_in[cnt_ff] = b;
               if (cnt_ff < 3'd3) begin
                  cnt_in = cnt_ff + 3'd1;
               end else begin
                  mode_in = jsu_pkg::MODE_TEXT;
                  cnt_in  = '0;
                  if (h0[4] || h1[4] || h2[4] || hb[4]) begin
                     emit_en  = 1'b1;
                     emit_val = jsu_pkg::CHAR_QMARK;
                  end else if (hexv >= jsu_pkg::SUR_HI_FIRST &&
                               hexv <= jsu_pkg::SUR_HI_LAST) begin
                     hs_in   = hexv[9:0];
                     mode_in = jsu_pkg::MODE_PAIR;
                  end else begin
                     code_go  = 1'b1;
                     code_val = 21'(hexv);
                  end
               end
            end
            jsu_pkg::MODE_PAIR: begin
               buf_in[cnt_ff] = b;
               if (pair_fail) begin
                  replay_go  = 1'b1;
                  replay_len = cnt_ff + 3'd1;
               end else if (cnt_ff < 3'd5) begin
                  cnt_in = cnt_ff + 3'd1;
               end else if (lov < jsu_pkg::SUR_LO_FIRST || lov > jsu_pkg::SUR_LO_LAST) begin
                  replay_go  = 1'b1;
                  replay_len = 3'd6;
               end else begin
                  mode_in  = jsu_pkg::MODE_TEXT;
                  cnt_in   = '0;
                  code_go  = 1'b1;
                  code_val = jsu_pkg::PLANE1_BASE + 21'({hs_ff, lov[9:0]});
               end
            end
            default: begin
               mode_in = jsu_pkg::MODE_TEXT;
            end
         endcase
      end

      // Flush a pending escape, or replay the held bytes, at the end of the string
      if (cmd.finish_step) begin
         if (mode_ff == jsu_pkg::MODE_ESC) begin
            mode_in  = jsu_pkg::MODE_TEXT;
            emit_en  = 1'b1;
            emit_val = jsu_pkg::CHAR_BSLASH;
         end else if (mode_ff != jsu_pkg::MODE_TEXT) begin
            replay_go  = 1'b1;
            replay_len = cnt_ff;
         end
      end

      // Start a replay of the held bytes
      if (replay_go) begin
         mode_in   = jsu_pkg::MODE_TEXT;
         cnt_in    = '0;
         rp_idx_in = '0;
         rp_len_in = replay_len;
         emit_en   = 1'b1;
         emit_val  = jsu_pkg::CHAR_QMARK;
      end

      // Encode a code point as UTF-8, first byte now
      if (code_go) begin
         code_in = code_val;
         priority if (code_val == '0) begin
            emit_en = 1'b0;
         end else if (code_val < 21'h80) begin
            emit_en  = 1'b1;
            emit_val = code_val[7:0];
         end else if (code_val < 21'h800) begin
            if (room2) begin
               emit_en  = 1'b1;
               emit_val = jsu_pkg::UTF_LEAD2 | {3'b0, code_val[10:6]};
               rem_in   = 2'd1;
            end else begin
               stopped_in = 1'b1;
               ovf_in     = 1'b1;
            end
         end else if (code_val >= 21'(jsu_pkg::SUR_HI_FIRST) &&
                      code_val <= 21'(jsu_pkg::SUR_LO_LAST)) begin
            emit_en  = 1'b1;
            emit_val = jsu_pkg::CHAR_QMARK;
         end else if (code_val < jsu_pkg::PLANE1_BASE) begin
            if (room3) begin
               emit_en  = 1'b1;
               emit_val = jsu_pkg::UTF_LEAD3 | {4'b0, code_val[15:12]};
               rem_in   = 2'd2;
            end else begin
               stopped_in = 1'b1;
               ovf_in     = 1'b1;
            end
         end else begin
            if (room4) begin
               emit_en  = 1'b1;
               emit_val = jsu_pkg::UTF_LEAD4 | {5'b0, code_val[20:18]};
               rem_in   = 2'd3;
            end else begin
               stopped_in = 1'b1;
               ovf_in     = 1'b1;
            end
         end
      end

      // Continuation bytes
      if (cmd.emit_next) begin
         unique case (rem_ff)
            2'd3:    six = code_ff[17:12];
            2'd2:    six = code_ff[11:6];
            default: six = code_ff[5:0];
         endcase
         emit_en  = 1'b1;
         emit_val = jsu_pkg::UTF_CONT | {2'b0, six};
         rem_in   = rem_ff - 2'd1;
      end

      // Load a data item
      if (emit_en) begin
         rsp_valid_in  = 1'b1;
         rsp_kind_in   = 1'b0;
         rsp_byte_in   = emit_val;
         rsp_length_in = '0;
         rsp_ovf_in    = 1'b0;
         rsp_last_in   = 1'b0;
         written_in    = written_ff + LENGTH_BITS'(1);
      end

      // Load the closing item and clear the string state
      if (cmd.close) begin
         rsp_valid_in  = 1'b1;
         rsp_kind_in   = 1'b1;
         rsp_byte_in   = '0;
         rsp_length_in = 16'(written_ff);
         rsp_ovf_in    = ovf_ff;
         rsp_last_in   = 1'b1;
         mode_in       = jsu_pkg::MODE_TEXT;
         cnt_in        = '0;
         hs_in         = '0;
         rem_in        = '0;
         rp_idx_in     = '0;
         rp_len_in     = '0;
         written_in    = '0;
         stopped_in    = 1'b0;
         ovf_in        = 1'b0;
      end
   end

   always_comb begin
      status.slot_free   = slot_free;
      status.more_replay = rp_idx_in < rp_len_in;
      status.more_emit   = rem_in != 2'd0;
      status.mode_text   = mode_in == jsu_pkg::MODE_TEXT;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= jsu_pkg::CAP_RESET;
         mode_ff      <= jsu_pkg::MODE_TEXT;
         cnt_ff       <= '0;
         hs_ff        <= '0;
         rem_ff       <= '0;
         rp_idx_ff    <= '0;
         rp_len_ff    <= '0;
         written_ff   <= '0;
         stopped_ff   <= 1'b0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) cap_ff <= csr_data;
         mode_ff      <= mode_in;
         cnt_ff       <= cnt_in;
         hs_ff        <= hs_in;
         rem_ff       <= rem_in;
         rp_idx_ff    <= rp_idx_in;
         rp_len_ff    <= rp_len_in;
         written_ff   <= written_in;
         stopped_ff   <= stopped_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      buf_ff        <= buf_in;
      code_ff       <= code_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_length_ff <= rsp_length_in;
      rsp_ovf_ff    <= rsp_ovf_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_kind     = rsp_kind_ff;
   assign rsp_byte     = rsp_byte_ff;
   assign rsp_length   = rsp_length_ff;
   assign rsp_overflow = rsp_ovf_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

// ----- hdl/json_string_unescape_utf8_top.sv -----
// JSON string unescaper to UTF-8: one escaped body byte per input item, one output byte
// per data item, and a closing item (tuser high, tlast high) with the length and an
// overflow flag after the byte marked tlast. A new input byte is taken only after every
// further output byte of a UTF-8 sequence, every byte replayed from the six-byte
// lookahead buffer after a failed escape, each end-of-string flush step and the closing
// item of the last byte have gone, one at a time, through the single output register,
// and input is held while the result side stalls. The user must write out_capacity
// through the csr channel only while the block is idle; the block does not enforce this.
module json_string_unescape_utf8_top #(
   parameter int LENGTH_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] in_byte
   input  logic        req_tlast,    // last_in
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,    // [7:0] out_byte, [23:8] out_length, [24] overflow
   output logic        rsp_tuser,    // record_kind
   output logic        rsp_tlast,    // last_out
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [16:0] csr_data      // out_capacity
);

   jsu_pkg::cmd_type    cmd;
   jsu_pkg::status_type status;
   logic [7:0]          rsp_byte;
   logic [15:0]         rsp_length;
   logic                rsp_overflow;

   assign csr_ready = 1'b1;

   jsu_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   jsu_datapath #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_byte     (req_tdata),
      .csr_valid    (csr_valid),
      .csr_data     (csr_data),
      .rsp_tready   (rsp_tready),
      .rsp_valid    (rsp_tvalid),
      .rsp_kind     (rsp_tuser),
      .rsp_byte     (rsp_byte),
      .rsp_length   (rsp_length),
      .rsp_overflow (rsp_overflow),
      .rsp_last     (rsp_tlast)
   );

   // Pack the result fields
   assign rsp_tdata = {7'b0, rsp_overflow, rsp_length, rsp_byte};

endmodule

// ----- tb/sv/json_string_unescape_utf8_top_test.sv -----
// Self-checking testbench for the JSON string unescaper with UTF-8 output.
module json_string_unescape_utf8_top_test;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_DATA_PER_ITEM = 9;
   localparam int IDLE_LIMIT = 3000;
   localparam int HOLD_OFF_CYCLES = 250;

   typedef struct packed {
      logic        kind;
      logic [7:0]  ob;
      logic [15:0] len;
      logic        ovf;
      logic        lst;
   } rec_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;    // [7:0] out_byte, [23:8] out_length, [24] overflow
   logic        rsp_tuser;    // record_kind
   logic        rsp_tlast;    // last_out
   logic        csr_valid;
   logic        csr_ready;
   logic [16:0] csr_data;     // out_capacity

   json_string_unescape_utf8_top #(.LENGTH_BITS(16)) uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   // Clock
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Decoder model state
   int unsigned        capacity;
   jsu_pkg::mode_type  dec_mode;
   logic [7:0]         held_bytes[6];
   int                 held_count;
   int unsigned        code_unit;
   int unsigned        high_unit;
   int unsigned        bytes_written;
   bit                 out_halted;
   bit                 overflow_flag;
   int                 item_bytes;

   rec_type expected_recs[$];
   int      fail_count;
   int      items_sent;
   bit      idle_enable;
   bit      hold_request;
   int      idle_cycles;

   function automatic int unsigned byte_cap();
      int unsigned lim;
      lim = (capacity == 0) ? 0 : capacity - 1;
      return (lim > 65535) ? 65535 : lim;
   endfunction

   function automatic int unsigned hex_of(logic [7:0] b);
      if (b >= "0" && b <= "9") return b - "0";
      if (b >= "a" && b <= "f") return b - "a" + 10;
      if (b >= "A" && b <= "F") return b - "A" + 10;
      return 16;
   endfunction

   // Record one data byte; only the first few of an item are visible
   function automatic void put_data(logic [7:0] b);
      rec_type r;
      if (item_bytes < MAX_DATA_PER_ITEM) begin
         r = '{kind: 1'b0, ob: b, len: 16'd0, ovf: 1'b0, lst: 1'b0};
         expected_recs.push_back(r);
         item_bytes++;
      end
      bytes_written++;
   endfunction

   function automatic void halt_out();
      out_halted = 1'b1;
      overflow_flag = 1'b1;
   endfunction

   function automatic bit fits(int unsigned k);
      return bytes_written + k <= byte_cap();
   endfunction

   function automatic void encode_utf8(int unsigned u);
      if (u == 0) return;
      if (u < 'h80) begin
         put_data(u[7:0]);
      end else if (u < 'h800) begin
         if (!fits(2)) begin
            halt_out();
            return;
         end
         put_data(8'(jsu_pkg::UTF_LEAD2 | (u >> 6)));
         put_data(8'(jsu_pkg::UTF_CONT | (u & 'h3F)));
      end else if (u >= jsu_pkg::SUR_HI_FIRST && u <= jsu_pkg::SUR_LO_LAST) begin
         put_data(jsu_pkg::CHAR_QMARK);
      end else if (u < 'h10000) begin
         if (!fits(3)) begin
            halt_out();
            return;
         end
         put_data(8'(jsu_pkg::UTF_LEAD3 | (u >> 12)));
         put_data(8'(jsu_pkg::UTF_CONT | ((u >> 6) & 'h3F)));
         put_data(8'(jsu_pkg::UTF_CONT | (u & 'h3F)));
      end else begin
         if (!fits(4)) begin
            halt_out();
            return;
         end
         put_data(8'(jsu_pkg::UTF_LEAD4 | (u >> 18)));
         put_data(8'(jsu_pkg::UTF_CONT | ((u >> 12) & 'h3F)));
         put_data(8'(jsu_pkg::UTF_CONT | ((u >> 6) & 'h3F)));
         put_data(8'(jsu_pkg::UTF_CONT | (u & 'h3F)));
      end
   endfunction

   // Emit '?' and run the held bytes through the decoder again
   function automatic void rerun_held();
      logic [7:0] saved[6];
      int n;
      saved = held_bytes;
      n = held_count;
      dec_mode = jsu_pkg::MODE_TEXT;
      held_count = 0;
      put_data(jsu_pkg::CHAR_QMARK);
      for (int k = 0; k < n; k++) decode_byte(saved[k]);
   endfunction

   function automatic void decode_byte(logic [7:0] b);
      int unsigned v;
      int k;
      case (dec_mode)
         jsu_pkg::MODE_ESC: begin
            dec_mode = jsu_pkg::MODE_TEXT;
            case (b)
               jsu_pkg::CHAR_LC_N: put_data(jsu_pkg::CODE_LF);
               jsu_pkg::CHAR_LC_T: put_data(jsu_pkg::CODE_TAB);
               jsu_pkg::CHAR_LC_R: put_data(jsu_pkg::CODE_CR);
               jsu_pkg::CHAR_LC_B: put_data(jsu_pkg::CODE_BS);
               jsu_pkg::CHAR_LC_F: put_data(jsu_pkg::CODE_FF);
               jsu_pkg::CHAR_LC_U: begin
                  dec_mode = jsu_pkg::MODE_HEX;
                  held_count = 0;
               end
               default: put_data(b);
            endcase
         end
         jsu_pkg::MODE_HEX: begin
            if (held_count < 4) held_bytes[held_count++] = b;
            if (held_count < 4) return;
            dec_mode = jsu_pkg::MODE_TEXT;
            held_count = 0;
            code_unit = 0;
            for (k = 0; k < 4; k++) begin
               v = hex_of(held_bytes[k]);
               if (v > 15) begin
                  put_data(jsu_pkg::CHAR_QMARK);
                  return;
               end
               code_unit = (code_unit << 4) | v;
            end
            if (code_unit >= jsu_pkg::SUR_HI_FIRST && code_unit <= jsu_pkg::SUR_HI_LAST) begin
               high_unit = code_unit;
               dec_mode = jsu_pkg::MODE_PAIR;
            end else begin
               encode_utf8(code_unit);
            end
         end
         jsu_pkg::MODE_PAIR: begin
            if (held_count < 6) held_bytes[held_count++] = b;
            k = held_count - 1;
            if ((k == 0 && b != jsu_pkg::CHAR_BSLASH) || (k == 1 && b != jsu_pkg::CHAR_LC_U) ||
                (k >= 2 && hex_of(b) > 15)) begin
               rerun_held();
               return;
            end
            if (held_count < 6) return;
            v = 0;
            for (k = 2; k < 6; k++) v = (v << 4) | hex_of(held_bytes[k]);
            if (v < jsu_pkg::SUR_LO_FIRST || v > jsu_pkg::SUR_LO_LAST) begin
               rerun_held();
               return;
            end
            dec_mode = jsu_pkg::MODE_TEXT;
            held_count = 0;
            encode_utf8(jsu_pkg::PLANE1_BASE + ((high_unit - jsu_pkg::SUR_HI_FIRST) << 10) +
                        (v - jsu_pkg::SUR_LO_FIRST));
         end
         default: begin
            dec_mode = jsu_pkg::MODE_TEXT;
            if (capacity == 0 || out_halted) return;
            if (bytes_written >= byte_cap()) begin
               halt_out();
               return;
            end
            if (b == jsu_pkg::CHAR_BSLASH) dec_mode = jsu_pkg::MODE_ESC;
            else put_data(b);
         end
      endcase
   endfunction

   function automatic void clear_body();
      dec_mode = jsu_pkg::MODE_TEXT;
      held_count = 0;
      code_unit = 0;
      high_unit = 0;
      bytes_written = 0;
      out_halted = 1'b0;
      overflow_flag = 1'b0;
   endfunction

   // Work out the results of one accepted byte
   function automatic void predict_byte(logic [7:0] b, logic lst);
      rec_type r;
      item_bytes = 0;
      decode_byte(b);
      if (lst) begin
         for (int g = 0; g < 16 && dec_mode != jsu_pkg::MODE_TEXT; g++) begin
            if (dec_mode == jsu_pkg::MODE_ESC) begin
               dec_mode = jsu_pkg::MODE_TEXT;
               put_data(jsu_pkg::CHAR_BSLASH);
            end else begin
               rerun_held();
            end
         end
         r = '{kind: 1'b1, ob: 8'd0, len: bytes_written[15:0], ovf: overflow_flag,
               lst: 1'b1};
         expected_recs.push_back(r);
         clear_body();
      end
   endfunction

   // Track accepted inputs and register writes
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) predict_byte(req_tdata, req_tlast);
      if (!reset && csr_valid && csr_ready) capacity = csr_data;
   end

   // Check each result against the oldest expectation
   always @(posedge clock) begin
      rec_type got;
      rec_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{kind: rsp_tuser, ob: rsp_tdata[7:0], len: rsp_tdata[23:8],
                 ovf: rsp_tdata[24], lst: rsp_tlast};
         if (expected_recs.size() == 0) begin
            $display("%0t: unexpected item kind=%0d byte=%02h len=%0d ovf=%0d last=%0d",
                     $time, got.kind, got.ob, got.len, got.ovf, got.lst);
            fail_count++;
         end else begin
            want = expected_recs.pop_front();
            if (got.kind != want.kind || got.ob != want.ob || got.len != want.len ||
                got.ovf != want.ovf || got.lst != want.lst) begin
               $display("%0t: mismatch expected kind=%0d byte=%02h len=%0d ovf=%0d last=%0d",
                        $time, want.kind, want.ob, want.len, want.ovf, want.lst);
               $display("%0t:          actual   kind=%0d byte=%02h len=%0d ovf=%0d last=%0d",
                        $time, got.kind, got.ob, got.len, got.ovf, got.lst);
               fail_count++;
            end
         end
      end
   end

   // Watchdog on cycles with no handshake at all
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles = 0;
      end else if (++idle_cycles >= IDLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Result side: random stalls and one long hold-off on request
   initial begin
      int n;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_tready = 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            hold_request = 1'b0;
            rsp_tready = 1'b1;
         end else if (idle_enable && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 16);
            rsp_tready = 1'b0;
            repeat (n - 1) @(negedge clock);
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   // Offer one item; valid stays high until the next item or a pause
   task automatic send_item(logic [7:0] b, logic lst);
      int gap;
      if (idle_enable && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 16);
         @(negedge clock);
         req_tvalid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata = b;
      req_tlast = lst;
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   task automatic send_body(logic [7:0] body[$]);
      foreach (body[i]) send_item(body[i], i == body.size() - 1);
   endtask

   // Drop valid and wait until every expected item has arrived
   task automatic drain();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (expected_recs.size() != 0) @(posedge clock);
   endtask

   task automatic write_capacity(logic [16:0] value);
      drain();
      repeat (20) @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_data = value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic void add_text(ref logic [7:0] q[$], input string s);
      for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
   endfunction

   function automatic void add_hex4(ref logic [7:0] q[$], input logic [15:0] v);
      string s;
      if ($urandom_range(0, 1) != 0) s = $sformatf("\\u%04x", v);
      else s = $sformatf("\\u%04X", v);
      add_text(q, s);
   endfunction

   // Directed bodies: simple escapes, unicode forms and the broken cases
   task automatic test_escapes();
      logic [7:0] q[$];
      q = {};
      add_text(q, "a\\n\\t\\r\\b\\f\\/\\\"\\\\\\q");
      q.push_back(8'h00);
      q.push_back(8'hFF);
      send_body(q);
      q = {};
      add_text(q, "\\u0000\\u00e9\\u20AC\\ud83d\\ude00\\udc00x");
      send_body(q);
      q = {};
      add_text(q, "\\ud800z\\u12g4\\ud800\\u0041\\");
      send_body(q);
      q = {};
      add_text(q, "\\ud83d\\u12");
      send_body(q);
      q = {};
      add_text(q, "\\u1");
      send_body(q);
   endtask

   // Capacity extremes: zero, one, multibyte at the edge, above the length range
   task automatic test_capacity();
      logic [7:0] q[$];
      logic [16:0] caps[6] = '{17'd0, 17'd1, 17'd2, 17'd4, 17'h1FFFF, 17'd65536};
      foreach (caps[i]) begin
         write_capacity(caps[i]);
         q = {};
         add_text(q, "ab\\u20ac\\ud83d\\ude00cd");
         send_body(q);
      end
      write_capacity(jsu_pkg::CAP_RESET);
   endtask

   function automatic void add_random_token(ref logic [7:0] q[$]);
      logic [15:0] v;
      case ($urandom_range(0, 9))
         0, 1: q.push_back(8'($urandom_range(32, 126)));
         2: q.push_back(8'($urandom_range(0, 255)));
         3: begin
            q.push_back(jsu_pkg::CHAR_BSLASH);
            q.push_back(8'($urandom_range(0, 255)));
         end
         4: add_hex4(q, 16'($urandom_range(0, 16'hFFFF)));
         5: add_hex4(q, 16'($urandom_range(0, 16'h7FF)));
         6: begin
            add_hex4(q, 16'($urandom_range(jsu_pkg::SUR_HI_FIRST, jsu_pkg::SUR_HI_LAST)));
            add_hex4(q, 16'($urandom_range(jsu_pkg::SUR_LO_FIRST, jsu_pkg::SUR_LO_LAST)));
         end
         7: begin
            add_hex4(q, 16'($urandom_range(jsu_pkg::SUR_HI_FIRST, jsu_pkg::SUR_HI_LAST)));
            v = 16'($urandom_range(0, 16'hFFFF));
            add_hex4(q, v);
            repeat ($urandom_range(0, 5)) void'(q.pop_back());
         end
         8: begin
            add_hex4(q, 16'($urandom_range(0, 16'hFFFF)));
            q[q.size() - $urandom_range(1, 4)] = 8'($urandom_range(0, 255));
         end
         default: add_text(q, "\\");
      endcase
   endfunction

   // Random bodies, mostly well formed, across several capacities
   task automatic test_random(int target);
      logic [7:0] q[$];
      int phase;
      phase = 0;
      while (items_sent < target) begin
         if (phase % 3 == 2) write_capacity(17'($urandom_range(1, 14)));
         else if (phase % 3 == 0) write_capacity(jsu_pkg::CAP_RESET);
         repeat (4) begin
            q = {};
            repeat ($urandom_range(1, 6)) add_random_token(q);
            send_body(q);
         end
         if ($urandom_range(0, 3) == 0) drain();
         phase++;
      end
   endtask

   // Hold the result side off while bytes keep coming
   task automatic test_backpressure();
      logic [7:0] q[$];
      drain();
      hold_request = 1'b1;
      q = {};
      repeat (12) add_random_token(q);
      send_body(q);
      drain();
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tlast = 1'b0;
      csr_valid = 1'b0;
      csr_data = '0;
      capacity = jsu_pkg::CAP_RESET;
      clear_body();
      fail_count = 0;
      items_sent = 0;
      idle_cycles = 0;
      hold_request = 1'b0;
      idle_enable = 1'b1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_escapes();
      test_capacity();
      test_backpressure();
      test_random(300);
      idle_enable = 1'b0;
      test_random(370);
      drain();
      repeat (40) @(posedge clock);
      if (fail_count == 0 && expected_recs.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
hdl/jsu_pkg.sv
hdl/jsu_ctrl.sv
hdl/jsu_datapath.sv
hdl/json_string_unescape_utf8_top.sv
tb/sv/json_string_unescape_utf8_top_test.sv
